@@ rtl/stc_pkg.sv @@
`timescale 1ns / 1ps

package stc_pkg;

  localparam int CANVAS_COLUMNS_DEF = 1024;
  localparam int CANVAS_ROWS_DEF = 32;

  localparam int COORD_W = 12;
  localparam int CHAN_W = 8;
  localparam int COLOR_W = 24;
  localparam int BLEND_W = 16;

  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 24'hFF7484;
  localparam logic LCD_MODE_RESET = 1'b1;

  typedef enum logic [0:0] {
    REG_TEXT_COLOR = 1'b0,
    REG_LCD_MODE   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_FILL      = 2'd0,
    KIND_COMPOSITE = 2'd1,
    KIND_MAX       = 2'd2,
    KIND_READ      = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [CHAN_W-1:0]  value_red;
    logic [CHAN_W-1:0]  value_green;
    logic [CHAN_W-1:0]  value_blue;
  } in_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] pixel_red;
    logic [CHAN_W-1:0] pixel_green;
    logic [CHAN_W-1:0] pixel_blue;
    logic              clipped;
  } out_rsp_t;

endpackage

@@ rtl/stc_store.sv @@
`timescale 1ns / 1ps

module stc_store
  import stc_pkg::*;
#(
  parameter int DEPTH = CANVAS_COLUMNS_DEF * CANVAS_ROWS_DEF,
  parameter int AW = $clog2(CANVAS_COLUMNS_DEF * CANVAS_ROWS_DEF)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [COLOR_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [COLOR_W-1:0] rdata
);

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/stc_chan.sv @@
`timescale 1ns / 1ps

module stc_chan
  import stc_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  kind_t             kind,
  input  logic [CHAN_W-1:0] dst,
  input  logic [CHAN_W-1:0] cov,
  input  logic [CHAN_W-1:0] color,
  output logic [CHAN_W-1:0] result
);

  logic [BLEND_W-1:0] sum_nxt;
  logic [BLEND_W-1:0] sum_r;
  logic [CHAN_W-1:0]  alt_nxt;
  logic [CHAN_W-1:0]  alt_r;
  logic [BLEND_W:0]   div_acc;

  always_comb begin
    sum_nxt = BLEND_W'(dst * (8'd255 - cov)) + BLEND_W'(color * cov) + BLEND_W'(127);
    case (kind)
      KIND_FILL: alt_nxt = cov;
      KIND_MAX:  alt_nxt = (dst > cov) ? dst : cov;
      default:   alt_nxt = dst;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
      alt_r <= alt_nxt;
    end
  end

  // Exact division by 255 for sums below 255 * 256.
  assign div_acc = {1'b0, sum_r} + (BLEND_W+1)'(sum_r >> 8) + (BLEND_W+1)'(1);
  assign result = (kind == KIND_COMPOSITE) ? div_acc[CHAN_W+7:8] : alt_r;

endmodule

@@ rtl/subpixel_text_compositor_top.sv @@
`timescale 1ns / 1ps
// Channel   Ports                          Payload
// input     in_valid / in_ready            in_req  (in_req_t)
// result    out_valid / out_ready          out_rsp (out_rsp_t)
// config    cfg_we, cfg_index, cfg_wdata   text_color, lcd_mode
//
// Each request goes through the frame store read, the blend products, then
// the divide, write back and load of the result register. The store's registered
// read and the product register separate those steps.
// Reset is synchronous and active low; the frame store is not cleared.
// A request is taken while a previous result still waits in the output
// register; the last step stalls until that register is free.

module subpixel_text_compositor_top
  import stc_pkg::*;
#(
  parameter int CANVAS_COLUMNS = CANVAS_COLUMNS_DEF,
  parameter int CANVAS_ROWS = CANVAS_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_req_t            in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output out_rsp_t           out_rsp,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [COLOR_W-1:0] cfg_wdata
);

  localparam int DEPTH = CANVAS_COLUMNS * CANVAS_ROWS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIN_W = 23;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_t;

  state_t             state_r;
  logic               out_valid_r;
  out_rsp_t           out_rsp_r;
  logic [COLOR_W-1:0] text_color_r;
  logic               lcd_mode_r;
  in_req_t            req_r;
  logic               clip_r;
  logic [AW-1:0]      addr_r;

  logic               accept;
  logic               finish;
  logic               clip_nxt;
  logic [LIN_W-1:0]   lin_addr;
  logic [AW-1:0]      addr_nxt;
  logic [COLOR_W-1:0] rd_data;
  logic [CHAN_W-1:0]  cov_g;
  logic [CHAN_W-1:0]  cov_b;
  logic [CHAN_W-1:0]  res_r;
  logic [CHAN_W-1:0]  res_g;
  logic [CHAN_W-1:0]  res_b;
  logic               wr_en;
  logic               calc_en;

  assign in_ready = (state_r == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign finish = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign calc_en = (state_r == ST_CALC);

  always_comb begin
    clip_nxt = in_req.x_coord[COORD_W-1] || in_req.y_coord[COORD_W-1] ||
               ({1'b0, in_req.x_coord} >= (COORD_W+1)'(CANVAS_COLUMNS)) ||
               ({1'b0, in_req.y_coord} >= (COORD_W+1)'(CANVAS_ROWS));
    lin_addr = LIN_W'(in_req.y_coord[COORD_W-2:0]) * LIN_W'(CANVAS_COLUMNS) +
               LIN_W'(in_req.x_coord[COORD_W-2:0]);
    addr_nxt = lin_addr[AW-1:0];
  end

  always_comb begin
    if (!lcd_mode_r && req_r.kind != KIND_FILL) begin
      cov_g = req_r.value_red;
      cov_b = req_r.value_red;
    end else begin
      cov_g = req_r.value_green;
      cov_b = req_r.value_blue;
    end
  end

  assign wr_en = finish && !clip_r && (req_r.kind != KIND_READ);

  stc_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr_r),
    .wdata ({res_r, res_g, res_b}),
    .re    (accept),
    .raddr (addr_nxt),
    .rdata (rd_data)
  );

  stc_chan u_chan_r (
    .clk    (clk),
    .en     (calc_en),
    .kind   (req_r.kind),
    .dst    (rd_data[23:16]),
    .cov    (req_r.value_red),
    .color  (text_color_r[23:16]),
    .result (res_r)
  );

  stc_chan u_chan_g (
    .clk    (clk),
    .en     (calc_en),
    .kind   (req_r.kind),
    .dst    (rd_data[15:8]),
    .cov    (cov_g),
    .color  (text_color_r[15:8]),
    .result (res_g)
  );

  stc_chan u_chan_b (
    .clk    (clk),
    .en     (calc_en),
    .kind   (req_r.kind),
    .dst    (rd_data[7:0]),
    .cov    (cov_b),
    .color  (text_color_r[7:0]),
    .result (res_b)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req;
      clip_r <= clip_nxt;
      addr_r <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= TEXT_COLOR_RESET;
      lcd_mode_r   <= LCD_MODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEXT_COLOR: text_color_r <= cfg_wdata;
        REG_LCD_MODE:   lcd_mode_r   <= cfg_wdata[0];
        default:        lcd_mode_r   <= lcd_mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !finish) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_CALC;
          end
        end
        ST_CALC: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (finish) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            if (clip_r) begin
              out_rsp_r <= '{pixel_red: '0, pixel_green: '0, pixel_blue: '0, clipped: 1'b1};
            end else begin
              out_rsp_r <= '{pixel_red: res_r, pixel_green: res_g, pixel_blue: res_b,
                             clipped: 1'b0};
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp = out_rsp_r;

endmodule
